// ----- rtl/fdrs_pkg.sv -----
`default_nettype none
package fdrs_pkg;

  // Queue geometry: two banks of QUEUE_DEPTH slots each
  localparam int QUEUE_DEPTH = 32;
  localparam int TRACK_BITS  = 16;
  localparam int TRK_W       = (TRACK_BITS < 16) ? TRACK_BITS : 16;
  localparam int SLOTS       = 2 * QUEUE_DEPTH;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_GRANT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] req_track;
    logic [31:0] req_arrival;
    logic [15:0] head_track;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] grant_track;
    logic [31:0] grant_arrival;
    logic        pending;
  } out_item_t;

  typedef struct packed {
    logic [TRK_W-1:0] trk;
    logic [31:0]      arr;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic add;
    logic swap;
    logic scan_init;
    logic flip;
    logic grant;
    logic empty;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic active_empty;
    logic add_empty;
    logic scan_done;
    logic found;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/fdrs_ctrl.sv -----
`default_nettype none
module fdrs_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire              in_op,
  input  fdrs_pkg::dp_sts_t sts,
  output fdrs_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import fdrs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_GRANT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       flipped_r, flipped_nxt;

  // Sequence one beat: add, or prepare / scan (up to two passes) / grant or report empty
  always_comb begin
    state_nxt   = state_r;
    flipped_nxt = flipped_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_GRANT) ? S_PREP : S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PREP: begin
        flipped_nxt = 1'b0;
        if (sts.active_empty && sts.add_empty) begin
          cmd.empty = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.swap      = sts.active_empty;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            state_nxt = S_GRANT;
          end else if (!flipped_r) begin
            cmd.flip    = 1'b1;
            flipped_nxt = 1'b1;
          end else begin
            cmd.empty = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      flipped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      flipped_r <= flipped_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/fdrs_dpath.sv -----
`default_nettype none
module fdrs_dpath (
  input  wire                clk,
  input  wire                rst_n,
  input  fdrs_pkg::in_item_t  in_data,
  input  fdrs_pkg::dp_cmd_t   cmd,
  output fdrs_pkg::dp_sts_t   sts,
  output fdrs_pkg::out_item_t out_data,
  output logic               out_strobe
);
  import fdrs_pkg::*;

  // Request store, read one slot per cycle during a scan
  entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid_r;

  logic [TRK_W-1:0] trk_r;
  logic [31:0]      arr_r;
  logic [TRK_W-1:0] head_r;

  logic             active_bank_r;
  logic             sweep_up_r;
  logic [CNT_W-1:0] active_cnt_r;
  logic [CNT_W-1:0] add_cnt_r;

  logic             run_r;
  logic [IDX_W-1:0] idx_r;
  logic             rd_vld_r;
  logic             rd_last_r;
  logic [SLOT_W-1:0] rd_slot_r;
  entry_t           rd_data_r;
  logic             done_r;

  logic             best_vld_r;
  logic [TRK_W-1:0] best_trk_r;
  logic [31:0]      best_arr_r;
  logic [SLOT_W-1:0] best_slot_r;

  out_item_t        out_r;
  logic             strobe_r;

  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] add_slot;
  logic              add_full;
  logic              cand_ok;
  logic              in_dir;
  logic              better;

  assign rd_addr  = active_bank_r ? (SLOT_W'(QUEUE_DEPTH) + SLOT_W'(idx_r)) : SLOT_W'(idx_r);
  assign add_slot = active_bank_r ? SLOT_W'(add_cnt_r) : (SLOT_W'(QUEUE_DEPTH) + SLOT_W'(add_cnt_r));
  assign add_full = (add_cnt_r == CNT_W'(QUEUE_DEPTH));

  // Compare the slot just read against the best so far
  always_comb begin
    in_dir  = sweep_up_r ? (rd_data_r.trk >= head_r) : (rd_data_r.trk <= head_r);
    cand_ok = rd_vld_r && valid_r[rd_slot_r] && in_dir;
    better  = !best_vld_r
           || (sweep_up_r ? (rd_data_r.trk < best_trk_r) : (rd_data_r.trk > best_trk_r))
           || ((rd_data_r.trk == best_trk_r) && (rd_data_r.arr < best_arr_r));
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.add && !add_full) begin
      mem[add_slot] <= '{trk: trk_r, arr: arr_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Latch the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trk_r  <= in_data.req_track[TRK_W-1:0];
      arr_r  <= in_data.req_arrival;
      head_r <= in_data.head_track[TRK_W-1:0];
    end
  end

  // Bank bookkeeping and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      active_bank_r <= 1'b0;
      sweep_up_r    <= 1'b1;
      active_cnt_r  <= '0;
      add_cnt_r     <= '0;
    end else begin
      if (cmd.add && !add_full) begin
        valid_r[add_slot] <= 1'b1;
        add_cnt_r         <= add_cnt_r + CNT_W'(1);
      end
      if (cmd.swap) begin
        active_bank_r <= ~active_bank_r;
        active_cnt_r  <= add_cnt_r;
        add_cnt_r     <= '0;
      end
      if (cmd.swap) begin
        sweep_up_r <= 1'b1;
      end else if (cmd.flip) begin
        sweep_up_r <= ~sweep_up_r;
      end
      if (cmd.grant) begin
        valid_r[best_slot_r] <= 1'b0;
        active_cnt_r         <= active_cnt_r - CNT_W'(1);
      end
    end
  end

  // Scan sequencer: issue one read a cycle, compare its data in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
      done_r     <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (cmd.scan_init || cmd.flip) begin
      run_r      <= 1'b1;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
      done_r     <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= run_r;
      rd_last_r <= run_r && (idx_r == IDX_W'(QUEUE_DEPTH - 1));
      rd_slot_r <= rd_addr;
      if (run_r) begin
        idx_r <= idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          run_r <= 1'b0;
        end
      end
      done_r <= rd_vld_r && rd_last_r;
      if (cand_ok && better) begin
        best_vld_r  <= 1'b1;
        best_trk_r  <= rd_data_r.trk;
        best_arr_r  <= rd_data_r.arr;
        best_slot_r <= rd_slot_r;
      end
    end
  end

  // Result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.add || cmd.grant || cmd.empty;
    end
    if (cmd.add) begin
      out_r.status        <= add_full ? ST_FULL : ST_ADDED;
      out_r.grant_track   <= '0;
      out_r.grant_arrival <= '0;
      out_r.pending       <= 1'b1;
    end else if (cmd.grant) begin
      out_r.status        <= ST_GRANTED;
      out_r.grant_track   <= 16'(best_trk_r);
      out_r.grant_arrival <= best_arr_r;
      out_r.pending       <= (active_cnt_r != CNT_W'(1)) || (add_cnt_r != '0);
    end else if (cmd.empty) begin
      out_r.status        <= ST_EMPTY;
      out_r.grant_track   <= '0;
      out_r.grant_arrival <= '0;
      out_r.pending       <= (active_cnt_r != '0) || (add_cnt_r != '0);
    end
  end

  assign sts.active_empty = (active_cnt_r == '0);
  assign sts.add_empty    = (add_cnt_r == '0);
  assign sts.scan_done    = done_r;
  assign sts.found        = best_vld_r;
  assign out_data         = out_r;
  assign out_strobe       = strobe_r;

endmodule
`default_nettype wire

// ----- rtl/flook_disk_request_scheduler.sv -----
// FLOOK disk request scheduler.
// Input channel: present a beat on in_data and raise start; the beat is taken at
// a rising edge where start is high and busy is low. op selects add or grant.
// Result channel: one result per input beat, shown on out_data for exactly one
// cycle while out_strobe is high. The receiver cannot hold results off.
// Sequencing: an add result is registered from the add state. A grant scans
// the active bank through the request store one slot per cycle with a single
// comparator in one pass, and scans the bank again when the sweep reverses.
// A grant with both banks empty returns its result from the prepare state.
// Throughput: one beat in flight at a time; busy stays high until the result
// cycle, in which a new beat may already be accepted.
// Reset (synchronous, rst_n low): all slots invalid, bank 0 active, sweep
// upward, no result pending. Stored request data is not cleared.
`default_nettype none
module flook_disk_request_scheduler (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  fdrs_pkg::in_item_t  in_data,
  output fdrs_pkg::out_item_t out_data,
  output logic               out_strobe
);
  import fdrs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fdrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_data.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fdrs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_data   (out_data),
    .out_strobe (out_strobe)
  );

endmodule
`default_nettype wire

// ----- rtl/fdrs_chk.sv -----
`default_nettype none
module fdrs_chk (
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input fdrs_pkg::out_item_t out_data,
  input wire                out_strobe
);
  import fdrs_pkg::*;

  // Reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_strobe)
    else $error("block not idle after reset");

  // An accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // Results never come back to back
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // Only a grant carries track and arrival
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.status != ST_GRANTED) |->
      (out_data.grant_track == '0) && (out_data.grant_arrival == '0))
    else $error("non-grant result carries grant fields");

  // A stored or dropped add always leaves work pending
  a_add_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_data.status == ST_ADDED) || (out_data.status == ST_FULL)) |->
      out_data.pending)
    else $error("add result reports nothing pending");

endmodule

bind flook_disk_request_scheduler fdrs_chk u_fdrs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_data   (out_data),
  .out_strobe (out_strobe)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdrs_pkg::*;

  // Slowest grant: two full passes over a bank plus overhead
  localparam int GRANT_WORST   = 2 * QUEUE_DEPTH + 8;
  localparam int SETTLE_CYCLES = GRANT_WORST + 8;
  localparam int STALL_LIMIT   = 20 * GRANT_WORST;
  localparam int RANDOM_BEATS  = 1550;
  localparam int MAX_SHOWN     = 10;

  // One directed row: the beat and, where typed in, its reply
  typedef struct packed {
    logic      fixed;
    in_item_t  beat;
    out_item_t reply;
  } plan_row_t;

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // grant right after reset finds nothing
    '{1'b1, '{OP_GRANT, 16'h5a5a, 32'ha5a5a5a5, 16'h1234}, '{ST_EMPTY, 16'h0, 32'h0, 1'b0}},
    // field extremes, then a three-way tie on track 100
    '{1'b1, '{OP_ADD, 16'h0000, 32'h00000000, 16'hffff}, '{ST_ADDED, 16'h0, 32'h0, 1'b1}},
    '{1'b1, '{OP_ADD, 16'hffff, 32'hffffffff, 16'h0000}, '{ST_ADDED, 16'h0, 32'h0, 1'b1}},
    '{1'b1, '{OP_ADD, 16'd100, 32'd5, 16'h0}, '{ST_ADDED, 16'h0, 32'h0, 1'b1}},
    '{1'b1, '{OP_ADD, 16'd100, 32'd3, 16'h0}, '{ST_ADDED, 16'h0, 32'h0, 1'b1}},
    '{1'b1, '{OP_ADD, 16'd100, 32'd3, 16'h0}, '{ST_ADDED, 16'h0, 32'h0, 1'b1}},
    '{1'b1, '{OP_ADD, 16'h8000, 32'd7, 16'h0}, '{ST_ADDED, 16'h0, 32'h0, 1'b1}},
    // first grant swaps banks, sweeps up, earliest arrival wins
    '{1'b1, '{OP_GRANT, 16'h0, 32'h0, 16'd50}, '{ST_GRANTED, 16'd100, 32'd3, 1'b1}},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'd100}, '0},
    '{1'b0, '{OP_ADD, 16'd40, 32'd9, 16'h0}, '0},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'h9000}, '0},
    // nothing at or above the head: sweep turns down
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'hffff}, '0},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'h7fff}, '0},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'h0050}, '0},
    // active bank drained: swap back, sweep reset upward
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'h0000}, '0},
    '{1'b1, '{OP_GRANT, 16'hffff, 32'hffffffff, 16'h0}, '{ST_EMPTY, 16'h0, 32'h0, 1'b0}},
    // equal track and equal arrival
    '{1'b0, '{OP_ADD, 16'd7, 32'd1, 16'h0}, '0},
    '{1'b0, '{OP_ADD, 16'd7, 32'd1, 16'h0}, '0},
    '{1'b0, '{OP_ADD, 16'd7, 32'd0, 16'h0}, '0},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'd7}, '0},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'd8}, '0},
    '{1'b0, '{OP_GRANT, 16'h0, 32'h0, 16'd8}, '0},
    '{1'b1, '{OP_GRANT, 16'h0, 32'h0, 16'hffff}, '{ST_EMPTY, 16'h0, 32'h0, 1'b0}}
  };

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  out_item_t out_data;
  logic      out_strobe;

  // Typed reply that travels with a directed beat
  logic      reply_fixed;
  out_item_t reply_value;

  // Scheduler mirror
  logic [15:0] slot_trk [SLOTS];
  logic [31:0] slot_arr [SLOTS];
  bit          slot_live [SLOTS];
  bit          serve_bank;
  bit          sweep_rising;

  out_item_t scheduler_replies [$];
  int        fault_count;
  int        quiet_cycles;

  flook_disk_request_scheduler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_data   (out_data),
    .out_strobe (out_strobe)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int live_in_bank(bit bank);
    int n;
    n = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (slot_live[int'(bank) * QUEUE_DEPTH + i]) n++;
    return n;
  endfunction

  // Nearest live slot of the serving bank in the given direction, or -1
  function automatic int nearest_slot(bit up, logic [15:0] head);
    int best;
    int s;
    best = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      s = int'(serve_bank) * QUEUE_DEPTH + i;
      if (!slot_live[s]) continue;
      if (up ? (slot_trk[s] < head) : (slot_trk[s] > head)) continue;
      if (best < 0) begin
        best = s;
      end else if ((up ? (slot_trk[s] < slot_trk[best]) : (slot_trk[s] > slot_trk[best])) ||
                   (slot_trk[s] == slot_trk[best] && slot_arr[s] < slot_arr[best])) begin
        best = s;
      end
    end
    return best;
  endfunction

  // Apply one beat to the mirror and return its reply
  function automatic out_item_t schedule_request(in_item_t beat);
    out_item_t r;
    int base;
    int pick;
    r = '0;
    if (beat.op == OP_ADD) begin
      r.status = ST_FULL;
      base = int'(!serve_bank) * QUEUE_DEPTH;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!slot_live[base + i]) begin
          slot_live[base + i] = 1'b1;
          slot_trk[base + i]  = beat.req_track;
          slot_arr[base + i]  = beat.req_arrival;
          r.status = ST_ADDED;
          break;
        end
      end
    end else begin
      if (live_in_bank(serve_bank) == 0 && live_in_bank(!serve_bank) != 0) begin
        serve_bank   = !serve_bank;
        sweep_rising = 1'b1;
      end
      r.status = ST_EMPTY;
      if (live_in_bank(serve_bank) != 0) begin
        pick = nearest_slot(sweep_rising, beat.head_track);
        if (pick < 0) begin
          sweep_rising = !sweep_rising;
          pick = nearest_slot(sweep_rising, beat.head_track);
        end
        if (pick >= 0) begin
          r.status        = ST_GRANTED;
          r.grant_track   = slot_trk[pick];
          r.grant_arrival = slot_arr[pick];
          slot_live[pick] = 1'b0;
        end
      end
    end
    r.pending = (live_in_bank(1'b0) + live_in_bank(1'b1)) != 0;
    return r;
  endfunction

  task automatic note_fault(string what, logic [31:0] want, logic [31:0] got);
    fault_count++;
    if (fault_count <= MAX_SHOWN)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // Track and watch both channels at every edge
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    bit        took;
    took = 1'b0;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_trk[i]  = '0;
        slot_arr[i]  = '0;
      end
      serve_bank   = 1'b0;
      sweep_rising = 1'b1;
    end else begin
      if (start && !busy) begin
        took = 1'b1;
        want = schedule_request(in_data);
        if (reply_fixed) want = reply_value;
        scheduler_replies = {scheduler_replies, want};
      end
      if (out_strobe) begin
        if (scheduler_replies.size() == 0) begin
          note_fault("result with nothing outstanding, status", '0, 32'(out_data.status));
        end else begin
          want = scheduler_replies.pop_front();
          if (out_data.status !== want.status)
            note_fault("status", 32'(want.status), 32'(out_data.status));
          if (out_data.grant_track !== want.grant_track)
            note_fault("grant_track", 32'(want.grant_track), 32'(out_data.grant_track));
          if (out_data.grant_arrival !== want.grant_arrival)
            note_fault("grant_arrival", want.grant_arrival, out_data.grant_arrival);
          if (out_data.pending !== want.pending)
            note_fault("pending", 32'(want.pending), 32'(out_data.pending));
        end
      end
    end
    // Give up when neither channel moves for too long
    if (took || out_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("flook_disk_request_scheduler verification failed");
      $finish;
    end
  end

  // Present one beat after a random gap, hold it until taken
  task automatic send_beat(in_item_t beat, logic fixed, out_item_t value);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_data     <= beat;
    reply_fixed <= fixed;
    reply_value <= value;
    do @(posedge clk); while (busy);
  endtask

  // Tracks at the extremes or clustered half the time, so ties and near misses are common
  function automatic logic [15:0] pick_track();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2, 3:    return 16'(1000 + $urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_arrival();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      2, 3:    return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_beat(logic op);
    in_item_t b;
    b.op          = op;
    b.req_track   = pick_track();
    b.req_arrival = pick_arrival();
    b.head_track  = pick_track();
    return b;
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    int mode;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    reply_fixed  = 1'b0;
    reply_value  = '0;
    fault_count  = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows
    for (int r = 0; r < PLAN_ROWS; r++)
      send_beat(PLAN[r].beat, PLAN[r].fixed, PLAN[r].reply);

    // Random episodes: overflow the add bank, mixed traffic, or drain
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      mode = (sent == 0) ? 0 : $urandom_range(0, 9);
      if (mode < 2) begin
        burst = QUEUE_DEPTH + $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) send_beat(random_beat(OP_ADD), 1'b0, '0);
      end else if (mode < 7) begin
        burst = $urandom_range(4, 40);
        for (int k = 0; k < burst; k++)
          send_beat(random_beat(($urandom_range(0, 9) < 4) ? OP_GRANT : OP_ADD), 1'b0, '0);
      end else begin
        burst = $urandom_range(8, 2 * QUEUE_DEPTH + 2);
        for (int k = 0; k < burst; k++) send_beat(random_beat(OP_GRANT), 1'b0, '0);
      end
      sent += burst;
    end
    start <= 1'b0;

    // Drain outstanding replies, then watch for strays
    while (scheduler_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && scheduler_replies.size() == 0)
      $display("flook_disk_request_scheduler verification clean");
    else
      $display("flook_disk_request_scheduler verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- flook_disk_request_scheduler.f -----
rtl/fdrs_pkg.sv
rtl/fdrs_ctrl.sv
rtl/fdrs_dpath.sv
rtl/flook_disk_request_scheduler.sv
rtl/fdrs_chk.sv
tb/sv/tb.sv
